### design/causal_depthwise_dilated_conv1d_macros.svh
// Assertion macros shared by the design files.
`ifndef CAUSAL_DEPTHWISE_DILATED_CONV1D_MACROS_SVH
`define CAUSAL_DEPTHWISE_DILATED_CONV1D_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### design/cddc_pkg.sv
package cddc_pkg;
   localparam int CHANNEL_W   = 6;
   localparam int TAP_IDX_W   = 4;
   localparam int DATA_W      = 16;
   localparam int ACC_W       = 40;
   localparam int TAP_CNT_W   = 5;
   localparam int DIL_W       = 4;
   localparam int SHIFT_W     = 5;
   localparam int CSR_IDX_W   = 2;

   localparam int DEF_MAX_CHANNELS  = 64;
   localparam int DEF_MAX_TAPS      = 16;
   localparam int DEF_MAX_DILATION  = 8;
   localparam int DEF_HISTORY_DEPTH = 128;

   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DILATION_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_SHIFT  = 2'd2;

   localparam logic [TAP_CNT_W-1:0] RST_TAP_COUNT     = 5'd4;
   localparam logic [DIL_W-1:0]     RST_DILATION_STEP = 4'd1;
   localparam logic [SHIFT_W-1:0]   RST_RESULT_SHIFT  = 5'd14;

   typedef struct packed {
      logic                 opcode;
      logic [CHANNEL_W-1:0] channel;
      logic [TAP_IDX_W-1:0] tap_index;
      logic [DATA_W-1:0]    data_value;
      logic                 sequence_start;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] out_channel;
      logic [DATA_W-1:0]    out_value;
      logic                 saturated;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          data;
   } csr_type;

   // accumulate step handed from the sequencer to the MAC
   typedef struct packed {
      logic clear;
      logic acc_en;
      logic tap_valid;
      logic finish;
   } mac_ctl_type;
endpackage

### design/cddc_if.sv
interface cddc_req_if;
   import cddc_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cddc_rsp_if;
   import cddc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cddc_csr_if;
   import cddc_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/cddc_mac.sv
`include "causal_depthwise_dilated_conv1d_macros.svh"
module cddc_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  cddc_pkg::mac_ctl_type         ctl,
   input  logic [cddc_pkg::DATA_W-1:0]   x_value,
   input  logic [cddc_pkg::DATA_W-1:0]   w_value,
   input  logic [cddc_pkg::SHIFT_W-1:0]  shift,
   output logic [cddc_pkg::DATA_W-1:0]   result,
   output logic                          result_sat,
   output logic                          done
);
   import cddc_pkg::*;

   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic                       fin_ff, fin_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rnd_ff, rnd_in;
   logic signed [ACC_W-1:0]    sum;
   logic signed [ACC_W:0]      rounded;
   logic signed [ACC_W:0]      shifted;
   logic signed [ACC_W:0]      bias;

   always_comb begin
      prod_in     = $signed(x_value) * $signed(w_value);
      prod_vld_in = ctl.acc_en && ctl.tap_valid;
      fin_in      = ctl.finish;
      sum         = acc_ff + (prod_vld_ff ? {{(ACC_W-2*DATA_W){prod_ff[2*DATA_W-1]}}, prod_ff}
                                          : '0);
      if (ctl.clear) begin
         acc_in = '0;
      end else begin
         acc_in = sum;
      end
      rnd_in = fin_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         prod_vld_ff <= 1'b0;
         fin_ff      <= 1'b0;
         rnd_ff      <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         fin_ff      <= fin_in;
         rnd_ff      <= rnd_in;
      end
   end

   // acc_ff holds the full sum in the cycle after the last product lands
   always_comb begin
      bias = '0;
      if (shift != '0) begin
         bias = (ACC_W+1)'(1) << (shift - SHIFT_W'(1));
      end
      rounded = {acc_ff[ACC_W-1], acc_ff} + bias;
      shifted = rounded >>> shift;
      if (shifted > (ACC_W+1)'(32767)) begin
         result     = 16'h7fff;
         result_sat = 1'b1;
      end else if (shifted < -(ACC_W+1)'(32768)) begin
         result     = 16'h8000;
         result_sat = 1'b1;
      end else begin
         result     = shifted[DATA_W-1:0];
         result_sat = 1'b0;
      end
   end

   assign done = rnd_ff;

   `CDC_ASSERT_IMPL(a_done_follows_finish, clock, reset, fin_ff |=> done, "done lost")
   `CDC_ASSERT_IMPL(a_no_acc_on_clear, clock, reset, ctl.clear |-> !ctl.acc_en,
      "clear with accumulate")
   `CDC_ASSERT_IMPL(a_done_single, clock, reset, done |=> !done, "done repeated")
endmodule

### design/cddc_engine.sv
`include "causal_depthwise_dilated_conv1d_macros.svh"
module cddc_engine #(
   parameter int MAX_CHANNELS  = cddc_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_TAPS      = cddc_pkg::DEF_MAX_TAPS,
   parameter int MAX_DILATION  = cddc_pkg::DEF_MAX_DILATION,
   parameter int HISTORY_DEPTH = cddc_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cddc_pkg::req_type              in_item,
   output logic                           out_valid,
   input  logic                           out_ready,
   output cddc_pkg::rsp_type              out_item,
   input  logic [cddc_pkg::TAP_CNT_W-1:0] tap_count,
   input  logic [cddc_pkg::DIL_W-1:0]     dilation_step,
   input  logic [cddc_pkg::SHIFT_W-1:0]   result_shift
);
   import cddc_pkg::*;

   localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int POS_W  = $clog2(HISTORY_DEPTH);
   localparam int TAP_AW = $clog2(MAX_TAPS);
   localparam int KC_W   = $clog2(MAX_TAPS + 1);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int LAG_W  = $clog2((MAX_TAPS - 1) * MAX_DILATION + 1) + 1;
   localparam int DC_W   = $clog2(MAX_DILATION + 1);
   localparam int HIST_N = MAX_CHANNELS * HISTORY_DEPTH;
   localparam int WGT_N  = MAX_CHANNELS * MAX_TAPS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_META  = 5'b00010,
      S_TAPS  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] hist_mem [HIST_N];
   logic [DATA_W-1:0] wgt_mem  [WGT_N];
   logic [POS_W-1:0]  wpos_mem [MAX_CHANNELS];
   logic [FILL_W-1:0] fill_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] meta_vld_ff;

   logic [CH_AW-1:0]  ch_ff;
   logic [DATA_W-1:0] data_ff;
   logic              start_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [KC_W-1:0]   k_ff;
   logic [DC_W-1:0]   d_ff;
   logic [KC_W-1:0]   j_ff, j_in;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic [2:0]        drain_ff, drain_in;
   logic [POS_W-1:0]  meta_pos_q;
   logic [FILL_W-1:0] meta_fill_q;
   logic [DATA_W-1:0] hist_q, wgt_q;
   logic              tap_ok_ff;
   logic [CHANNEL_W-1:0] out_ch_ff;
   logic [DATA_W-1:0] out_val_ff;
   logic              out_sat_ff;
   logic              out_vld_ff, out_vld_in;
   logic              tap_valid_d1, last_d1;

   logic              accept, ch_ok, is_sample;
   logic [CH_AW-1:0]  meta_addr;
   logic [POS_W-1:0]  cur_pos;
   logic [FILL_W-1:0] cur_fill, new_fill;
   logic [KC_W-1:0]   k_eff;
   logic [DC_W-1:0]   d_eff;
   logic [POS_W-1:0]  rd_slot;
   logic              tap_ok;
   logic [TAP_AW-1:0] j_idx;
   mac_ctl_type       mac_ctl;
   logic [DATA_W-1:0] mac_res;
   logic              mac_sat, mac_done;

   assign in_ready  = (state_ff == S_IDLE) && !out_vld_ff;
   assign accept    = in_valid && in_ready;
   assign ch_ok     = 32'(in_item.channel) < MAX_CHANNELS;
   assign is_sample = in_item.opcode == OP_SAMPLE;

   always_comb begin
      k_eff = KC_W'(tap_count);
      if (tap_count == '0) k_eff = KC_W'(1);
      if (32'(tap_count) > MAX_TAPS) k_eff = KC_W'(MAX_TAPS);
      d_eff = DC_W'(dilation_step);
      if (dilation_step == '0) d_eff = DC_W'(1);
      if (32'(dilation_step) > MAX_DILATION) d_eff = DC_W'(MAX_DILATION);
   end

   // read the incoming channel's metadata at the accepting edge
   assign meta_addr = (state_ff == S_IDLE) ? in_item.channel[CH_AW-1:0] : ch_ff;

   // metadata read of the latched channel, invalid entries read as zero
   assign cur_pos  = meta_vld_ff[ch_ff] ? meta_pos_q : '0;
   assign cur_fill = (meta_vld_ff[ch_ff] && !start_ff) ? meta_fill_q : '0;
   assign new_fill = (32'(cur_fill) < HISTORY_DEPTH) ? cur_fill + FILL_W'(1) : cur_fill;

   assign j_idx   = j_ff[TAP_AW-1:0];
   assign tap_ok  = 32'(lag_ff) < 32'(fill_ff);
   assign rd_slot = pos_ff - lag_ff[POS_W-1:0];

   always_ff @(posedge clock) begin
      if (accept && ch_ok && !is_sample && 32'(in_item.tap_index) < MAX_TAPS) begin
         wgt_mem[{in_item.channel[CH_AW-1:0], in_item.tap_index[TAP_AW-1:0]}]
            <= in_item.data_value;
      end
      meta_pos_q  <= wpos_mem[meta_addr];
      meta_fill_q <= fill_mem[meta_addr];
      if (state_ff == S_META) begin
         wpos_mem[ch_ff] <= cur_pos + POS_W'(1);
         fill_mem[ch_ff] <= new_fill;
         hist_mem[{ch_ff, cur_pos}] <= data_ff;
      end
      // the sample just written is forwarded for lag zero
      if (state_ff == S_TAPS) begin
         hist_q <= (lag_ff == '0) ? data_ff : hist_mem[{ch_ff, rd_slot}];
         wgt_q  <= wgt_mem[{ch_ff, j_idx}];
      end
   end

   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      lag_in     = lag_ff;
      drain_in   = drain_ff;
      out_vld_in = out_vld_ff && !out_ready;
      mac_ctl    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && ch_ok && is_sample) state_in = S_META;
         end
         S_META: begin
            j_in     = '0;
            lag_in   = LAG_W'(k_ff - KC_W'(1)) * LAG_W'(d_ff);
            mac_ctl.clear = 1'b1;
            state_in = S_TAPS;
         end
         S_TAPS: begin
            j_in   = j_ff + KC_W'(1);
            lag_in = lag_ff - LAG_W'(d_ff);
            if (j_ff == k_ff - KC_W'(1)) begin
               state_in = S_DRAIN;
               drain_in = '0;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 3'd1;
            if (mac_done) state_in = S_OUT;
         end
         S_OUT: begin
            out_vld_in = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // memory data valid in the cycle after the S_TAPS read
      mac_ctl.acc_en    = tap_valid_d1;
      mac_ctl.tap_valid = tap_ok_ff;
      mac_ctl.finish    = last_d1;
   end

   always_ff @(posedge clock) begin
      tap_ok_ff <= tap_ok;
      if (reset) begin
         state_ff     <= S_IDLE;
         meta_vld_ff  <= '0;
         out_vld_ff   <= 1'b0;
         tap_valid_d1 <= 1'b0;
         last_d1      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_vld_ff   <= out_vld_in;
         tap_valid_d1 <= state_ff == S_TAPS;
         last_d1      <= (state_ff == S_TAPS) && (state_in == S_DRAIN);
         if (state_ff == S_META) meta_vld_ff[ch_ff] <= 1'b1;
      end
      j_ff     <= j_in;
      lag_ff   <= lag_in;
      drain_ff <= drain_in;
      if (accept) begin
         ch_ff    <= in_item.channel[CH_AW-1:0];
         data_ff  <= in_item.data_value;
         start_ff <= in_item.sequence_start;
         k_ff     <= k_eff;
         d_ff     <= d_eff;
      end
      if (state_ff == S_META) begin
         pos_ff  <= cur_pos;
         fill_ff <= new_fill;
      end
      if (state_ff == S_OUT) begin
         out_ch_ff  <= CHANNEL_W'(ch_ff);
         out_val_ff <= mac_res;
         out_sat_ff <= mac_sat;
      end
   end

   cddc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .x_value    (hist_q),
      .w_value    (wgt_q),
      .shift      (result_shift),
      .result     (mac_res),
      .result_sat (mac_sat),
      .done       (mac_done)
   );

   assign out_valid            = out_vld_ff;
   assign out_item.out_channel = out_ch_ff;
   assign out_item.out_value   = out_val_ff;
   assign out_item.saturated   = out_sat_ff;

   `CDC_ASSERT_IMPL(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !in_ready,
      "ready while busy")
   `CDC_ASSERT_IMPL(a_out_after_out_state, clock, reset, (state_ff == S_OUT) |=> out_valid,
      "result lost")
   `CDC_ASSERT_IMPL(a_drain_bounded, clock, reset, (state_ff == S_DRAIN) |-> (drain_ff < 3'd5),
      "drain stuck")
endmodule

### design/causal_depthwise_dilated_conv1d.sv
// Causal depthwise dilated 1-D convolution over up to MAX_CHANNELS
// interleaved channels. A weight-load transaction (opcode 0) is written
// when accepted and gives no result. A sample transaction (opcode 1)
// writes the channel's history ring and produces one result: for each of
// the K effective taps, one history and one weight read from the
// single-port sample and weight memories, then the MAC pipeline drains,
// rounds, shifts and saturates. A new transaction is taken once the
// previous result has been delivered. No clearing pass is needed after
// reset; per-channel ring pointers read as zero until used.
`include "causal_depthwise_dilated_conv1d_macros.svh"
module causal_depthwise_dilated_conv1d #(
   parameter int MAX_CHANNELS  = cddc_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_TAPS      = cddc_pkg::DEF_MAX_TAPS,
   parameter int MAX_DILATION  = cddc_pkg::DEF_MAX_DILATION,
   parameter int HISTORY_DEPTH = cddc_pkg::DEF_HISTORY_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   cddc_req_if.sink    req,
   cddc_rsp_if.source  rsp,
   cddc_csr_if.sink    csr
);
   import cddc_pkg::*;

   logic [TAP_CNT_W-1:0] tap_count_ff;
   logic [DIL_W-1:0]     dilation_step_ff;
   logic [SHIFT_W-1:0]   result_shift_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= RST_TAP_COUNT;
         dilation_step_ff <= RST_DILATION_STEP;
         result_shift_ff  <= RST_RESULT_SHIFT;
      end else if (csr.valid) begin
         case (csr.payload.index)
            CSR_TAP_COUNT:     tap_count_ff     <= csr.payload.data[TAP_CNT_W-1:0];
            CSR_DILATION_STEP: dilation_step_ff <= csr.payload.data[DIL_W-1:0];
            CSR_RESULT_SHIFT:  result_shift_ff  <= csr.payload.data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   cddc_engine #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_TAPS      (MAX_TAPS),
      .MAX_DILATION  (MAX_DILATION),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_item       (req.payload),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .out_item      (rsp.payload),
      .tap_count     (tap_count_ff),
      .dilation_step (dilation_step_ff),
      .result_shift  (result_shift_ff)
   );

   `CDC_ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid,
      "response dropped")
   `CDC_ASSERT_IMPL(a_one_busy, clock, reset, (rsp.valid && !rsp.ready) |-> !req.ready,
      "input taken while result waits")
   `CDC_ASSERT_ALWAYS(a_reset_csr, clock, $past(reset) |-> (tap_count_ff == RST_TAP_COUNT),
      "tap count reset")
endmodule
